>>> hw/rtl/dta_pkg.sv
`timescale 1ns / 1ps

package dta_pkg;

  // Table geometry
  localparam int TABLE_ENTRIES = 1024;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int LF_W          = IDX_W + 1;
  localparam int FIRST_USER    = 2;

  // Occupancy bitmap: one bit per slot, MAP_W slots per row
  localparam int MAP_W    = (TABLE_ENTRIES < 32) ? TABLE_ENTRIES : 32;
  localparam int BIT_W    = $clog2(MAP_W);
  localparam int MAP_ROWS = TABLE_ENTRIES / MAP_W;
  localparam int ROW_W    = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1;

  // Word fields
  localparam int MODE_W   = 2;
  localparam int DESC_W   = 10;
  localparam int HANDLE_W = 32;
  localparam int STATUS_W = 2;
  localparam int TDATA_W  = ((DESC_W + HANDLE_W + 7) / 8) * 8;

  localparam logic [MODE_W-1:0] MODE_OPEN   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CLOSE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_FAIL = 2'd2,
    ST_BAD  = 2'd3
  } status_e;

  typedef struct packed {
    status_e             status;
    logic [DESC_W-1:0]   rdesc;
    logic [HANDLE_W-1:0] rhandle;
  } res_t;

  typedef struct packed {
    logic                we;
    logic [IDX_W-1:0]    waddr;
    logic [HANDLE_W-1:0] wdata;
    logic [IDX_W-1:0]    raddr;
  } hreq_t;

  typedef struct packed {
    logic             we;
    logic [ROW_W-1:0] waddr;
    logic [MAP_W-1:0] wdata;
    logic [ROW_W-1:0] raddr;
  } mreq_t;

  typedef struct packed {
    logic             clearing;
    logic [LF_W-1:0]  lowest_free;
    logic [IDX_W-1:0] highest_used;
  } stat_t;

  // Lowest clear bit; only meaningful when one exists
  function automatic logic [BIT_W-1:0] first_zero(input logic [MAP_W-1:0] v);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = MAP_W - 1; i >= 0; i--) begin
      if (!v[i]) idx = BIT_W'(i);
    end
    return idx;
  endfunction

  // Highest set bit; only meaningful when one exists
  function automatic logic [BIT_W-1:0] last_one(input logic [MAP_W-1:0] v);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < MAP_W; i++) begin
      if (v[i]) idx = BIT_W'(i);
    end
    return idx;
  endfunction

  // Bits 0..b set
  function automatic logic [MAP_W-1:0] mask_upto(input logic [BIT_W-1:0] b);
    return {MAP_W{1'b1}} >> (BIT_W'(MAP_W - 1) - b);
  endfunction

endpackage

>>> hw/rtl/descriptor_table_allocator.sv
`timescale 1ns / 1ps

// Descriptor table allocator: maps descriptor indices 2..TABLE_ENTRIES-1 to
// nonzero 32-bit handles (0 and 1 are reserved). Input word: tuser = mode
// (0 open, 1 close, 2 lookup), tdata = descriptor, file_handle. Output word:
// tuser = status (0 ok, 1 full, 2 open failed, 3 bad/empty descriptor),
// tdata = result_descriptor, result_handle. One output word per input word,
// in order. Handles sit in a 1024x32 RAM; occupancy sits in a separate
// bitmap RAM of 32 rows by 32 bits, and every scan walks that bitmap one row
// per cycle through its single read port. After reset the block sweeps the
// bitmap clear with tready low. A lookup or any failing operation goes from
// the check state straight to the response state; a successful open or close
// first runs the lowest-free forward scan (open) or the highest-used downward
// scan (close) across the bitmap rows. No new input word is accepted until
// the controller is back in idle. A finished word waits in the output
// register while the next input word is accepted.

module descriptor_table_allocator (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // slave side
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [dta_pkg::TDATA_W-1:0]  s_axis_tdata_i,   // [9:0] descriptor, [41:10] file_handle
  input  logic [dta_pkg::MODE_W-1:0]   s_axis_tuser_i,   // [1:0] mode
  // master side
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic [dta_pkg::TDATA_W-1:0]  m_axis_tdata_o,   // [9:0] result_descriptor,
                                                         // [41:10] result_handle
  output logic [dta_pkg::STATUS_W-1:0] m_axis_tuser_o    // [1:0] status
);

  localparam int DESC_W   = dta_pkg::DESC_W;
  localparam int HANDLE_W = dta_pkg::HANDLE_W;

  dta_pkg::hreq_t              hreq;
  dta_pkg::mreq_t              mreq;
  dta_pkg::res_t               res;
  dta_pkg::stat_t              stat;
  logic [HANDLE_W-1:0]         hnd_rdata;
  logic [dta_pkg::MAP_W-1:0]   map_rdata;
  logic                        res_valid;
  logic                        out_free;

  // output register
  logic                        out_valid_q;
  dta_pkg::res_t               out_q;

  assign out_free = !out_valid_q || m_axis_tready_i;

  dta_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_mode_i   (s_axis_tuser_i),
    .in_desc_i   (s_axis_tdata_i[DESC_W-1:0]),
    .in_handle_i (s_axis_tdata_i[DESC_W+HANDLE_W-1:DESC_W]),
    .out_free_i  (out_free),
    .res_valid_o (res_valid),
    .res_o       (res),
    .hreq_o      (hreq),
    .hnd_rdata_i (hnd_rdata),
    .mreq_o      (mreq),
    .map_rdata_i (map_rdata),
    .stat_o      (stat)
  );

  // handle store; contents only trusted where the bitmap says occupied
  dta_ram #(
    .DEPTH (dta_pkg::TABLE_ENTRIES),
    .WIDTH (HANDLE_W)
  ) u_hnd_ram (
    .clk_i   (clk_i),
    .we_i    (hreq.we),
    .waddr_i (hreq.waddr),
    .wdata_i (hreq.wdata),
    .raddr_i (hreq.raddr),
    .rdata_o (hnd_rdata)
  );

  // occupancy bitmap
  dta_ram #(
    .DEPTH (dta_pkg::MAP_ROWS),
    .WIDTH (dta_pkg::MAP_W)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (mreq.we),
    .waddr_i (mreq.waddr),
    .wdata_i (mreq.wdata),
    .raddr_i (mreq.raddr),
    .rdata_o (map_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_q.status;
  assign m_axis_tdata_o  = dta_pkg::TDATA_W'({out_q.rhandle, out_q.rdesc});

`ifndef ASSERT_OFF
  // no word taken while the bitmap is being swept
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.clearing |-> !s_axis_tready_o)
    else $error("input accepted during bitmap clear");

  // a new result never overwrites an undelivered one
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> (!out_valid_q || m_axis_tready_i))
    else $error("result overwrote pending output word");

  // free pointer never in the reserved range; used pointer never below 1 (empty)
  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stat.lowest_free >= dta_pkg::LF_W'(dta_pkg::FIRST_USER)) &&
    (stat.highest_used >= dta_pkg::IDX_W'(dta_pkg::FIRST_USER - 1)))
    else $error("free/used pointer in reserved range");

  // a successful open never hands out a reserved descriptor
  a_open_desc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res.status == dta_pkg::ST_OK && res.rdesc != '0) |->
      (res.rdesc >= DESC_W'(dta_pkg::FIRST_USER)))
    else $error("reserved descriptor allocated");
`endif

endmodule

>>> hw/rtl/dta_ram.sv
`timescale 1ns / 1ps

module dta_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

>>> hw/rtl/dta_ctrl.sv
`timescale 1ns / 1ps

module dta_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [dta_pkg::MODE_W-1:0]    in_mode_i,
  input  logic [dta_pkg::DESC_W-1:0]    in_desc_i,
  input  logic [dta_pkg::HANDLE_W-1:0]  in_handle_i,
  input  logic                          out_free_i,
  output logic                          res_valid_o,
  output dta_pkg::res_t                 res_o,
  output dta_pkg::hreq_t                hreq_o,
  input  logic [dta_pkg::HANDLE_W-1:0]  hnd_rdata_i,
  output dta_pkg::mreq_t                mreq_o,
  input  logic [dta_pkg::MAP_W-1:0]     map_rdata_i,
  output dta_pkg::stat_t                stat_o
);

  localparam int IDX_W = dta_pkg::IDX_W;
  localparam int LF_W  = dta_pkg::LF_W;
  localparam int ROW_W = dta_pkg::ROW_W;
  localparam int BIT_W = dta_pkg::BIT_W;
  localparam int MAP_W = dta_pkg::MAP_W;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_FWD,
    S_DOWN,
    S_RESP
  } state_e;

  state_e                        state_q, state_d;
  logic [ROW_W-1:0]              clr_q, clr_d;
  logic [LF_W-1:0]               lf_q, lf_d;
  logic [IDX_W-1:0]              hu_q, hu_d;
  logic [dta_pkg::MODE_W-1:0]    mode_q, mode_d;
  logic [dta_pkg::DESC_W-1:0]    desc_q, desc_d;
  logic [dta_pkg::HANDLE_W-1:0]  handle_q, handle_d;
  logic [ROW_W-1:0]              row_q, row_d;
  logic [MAP_W-1:0]              bits_q, bits_d;
  logic [MAP_W-1:0]              mask_q, mask_d;
  logic                          use_reg_q, use_reg_d;
  dta_pkg::res_t                 res_q, res_d;

  logic [IDX_W-1:0] in_idx, lf_idx, d_idx;
  logic [ROW_W-1:0] lf_row, d_row, hu_row;
  logic [BIT_W-1:0] lf_bit, d_bit, hu_bit;
  logic             lf_full, d_ok;
  logic [MAP_W-1:0] set_row, clr_row, fwd_bits, down_bits;

  assign in_idx = IDX_W'(in_desc_i);
  assign lf_idx = IDX_W'(lf_q);
  assign d_idx  = IDX_W'(desc_q);
  assign lf_row = ROW_W'(lf_idx >> BIT_W);
  assign d_row  = ROW_W'(d_idx >> BIT_W);
  assign hu_row = ROW_W'(hu_q >> BIT_W);
  assign lf_bit = BIT_W'(lf_idx);
  assign d_bit  = BIT_W'(d_idx);
  assign hu_bit = BIT_W'(hu_q);

  assign lf_full = lf_q >= LF_W'(dta_pkg::TABLE_ENTRIES);
  // in range, not reserved, and slot occupied
  assign d_ok = (32'(desc_q) < dta_pkg::TABLE_ENTRIES) &&
                (32'(desc_q) >= dta_pkg::FIRST_USER) && map_rdata_i[d_bit];

  assign set_row   = map_rdata_i | (MAP_W'(1) << lf_bit);
  assign clr_row   = map_rdata_i & ~(MAP_W'(1) << d_bit);
  assign fwd_bits  = use_reg_q ? bits_q : map_rdata_i;
  assign down_bits = (use_reg_q ? bits_q : map_rdata_i) & mask_q;

  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_RESP) && out_free_i;
  assign res_o       = res_q;

  assign stat_o.clearing     = (state_q == S_CLEAR);
  assign stat_o.lowest_free  = lf_q;
  assign stat_o.highest_used = hu_q;

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    lf_d      = lf_q;
    hu_d      = hu_q;
    mode_d    = mode_q;
    desc_d    = desc_q;
    handle_d  = handle_q;
    row_d     = row_q;
    bits_d    = bits_q;
    mask_d    = mask_q;
    use_reg_d = use_reg_q;
    res_d     = res_q;
    hreq_o    = '0;
    mreq_o    = '0;

    case (state_q)
      S_CLEAR: begin
        mreq_o.we    = 1'b1;
        mreq_o.waddr = clr_q;
        clr_d        = clr_q + ROW_W'(1);
        if (clr_q == ROW_W'(dta_pkg::MAP_ROWS - 1)) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        hreq_o.raddr = in_idx;
        mreq_o.raddr = (in_mode_i == dta_pkg::MODE_OPEN) ? lf_row : ROW_W'(in_idx >> BIT_W);
        if (in_valid_i) begin
          mode_d   = in_mode_i;
          desc_d   = in_desc_i;
          handle_d = in_handle_i;
          state_d  = S_CHECK;
        end
      end

      S_CHECK: begin
        res_d.status  = dta_pkg::ST_BAD;
        res_d.rdesc   = '0;
        res_d.rhandle = '0;
        state_d       = S_RESP;
        case (mode_q)
          dta_pkg::MODE_OPEN: begin
            if (lf_full) begin
              res_d.status = dta_pkg::ST_FULL;
            end else if (handle_q == '0) begin
              res_d.status = dta_pkg::ST_FAIL;
            end else begin
              hreq_o.we    = 1'b1;
              hreq_o.waddr = lf_idx;
              hreq_o.wdata = handle_q;
              mreq_o.we    = 1'b1;
              mreq_o.waddr = lf_row;
              mreq_o.wdata = set_row;
              res_d.status = dta_pkg::ST_OK;
              res_d.rdesc  = dta_pkg::DESC_W'(lf_idx);
              if (lf_idx > hu_q) hu_d = lf_idx;
              // forward scan starts in the freshly written row, slots up to lf taken
              row_d     = lf_row;
              bits_d    = set_row | dta_pkg::mask_upto(lf_bit);
              use_reg_d = 1'b1;
              state_d   = S_FWD;
            end
          end
          dta_pkg::MODE_CLOSE: begin
            if (d_ok) begin
              mreq_o.we    = 1'b1;
              mreq_o.waddr = d_row;
              mreq_o.wdata = clr_row;
              res_d.status = dta_pkg::ST_OK;
              if (LF_W'(d_idx) < lf_q) lf_d = LF_W'(d_idx);
              row_d  = hu_row;
              mask_d = dta_pkg::mask_upto(hu_bit);
              // same row as the write: forward the new value
              if (hu_row == d_row) begin
                bits_d    = clr_row;
                use_reg_d = 1'b1;
              end else begin
                mreq_o.raddr = hu_row;
                use_reg_d    = 1'b0;
              end
              state_d = S_DOWN;
            end
          end
          dta_pkg::MODE_LOOKUP: begin
            if (d_ok) begin
              res_d.status  = dta_pkg::ST_OK;
              res_d.rhandle = hnd_rdata_i;
            end
          end
          default: begin
          end
        endcase
      end

      S_FWD: begin
        if (|(~fwd_bits)) begin
          lf_d    = (LF_W'(row_q) << BIT_W) | LF_W'(dta_pkg::first_zero(fwd_bits));
          state_d = S_RESP;
        end else if (row_q == ROW_W'(dta_pkg::MAP_ROWS - 1)) begin
          lf_d    = LF_W'(dta_pkg::TABLE_ENTRIES);
          state_d = S_RESP;
        end else begin
          row_d        = row_q + ROW_W'(1);
          mreq_o.raddr = row_q + ROW_W'(1);
          use_reg_d    = 1'b0;
        end
      end

      S_DOWN: begin
        if (|down_bits) begin
          hu_d    = (IDX_W'(row_q) << BIT_W) | IDX_W'(dta_pkg::last_one(down_bits));
          state_d = S_RESP;
        end else if (row_q == '0) begin
          // reserved slots are never set: table empty
          hu_d    = IDX_W'(dta_pkg::FIRST_USER - 1);
          state_d = S_RESP;
        end else begin
          row_d        = row_q - ROW_W'(1);
          mreq_o.raddr = row_q - ROW_W'(1);
          mask_d       = '1;
          use_reg_d    = 1'b0;
        end
      end

      S_RESP: begin
        if (out_free_i) state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      lf_q    <= LF_W'(dta_pkg::FIRST_USER);
      hu_q    <= IDX_W'(dta_pkg::FIRST_USER - 1);
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      lf_q    <= lf_d;
      hu_q    <= hu_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q    <= mode_d;
    desc_q    <= desc_d;
    handle_q  <= handle_d;
    row_q     <= row_d;
    bits_q    <= bits_d;
    mask_q    <= mask_d;
    use_reg_q <= use_reg_d;
    res_q     <= res_d;
  end

endmodule

>>> tb/sv/tb_descriptor_table_allocator.sv
`timescale 1ns / 1ps

// Testbench for descriptor_table_allocator.
// A shadow copy of the descriptor table predicts the status, descriptor and
// handle of every input word at the edge where it is accepted. The checker
// compares each output word with the oldest prediction. Traffic runs through
// several phases: directed corner cases, mixed random traffic, a fill to a
// full table under a long output hold-off, a release of the upper block of
// slots, and closing random traffic.

module tb_descriptor_table_allocator;
  import dta_pkg::*;

  // Quiet cycles allowed before the run is declared hung, well above the
  // slowest word and the longest output hold-off (HOLD_CYCLES).
  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [TDATA_W-1:0]  s_axis_tdata_i  = '0;  // [9:0] descriptor, [41:10] file_handle
  logic [MODE_W-1:0]   s_axis_tuser_i  = '0;  // [1:0] mode
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [TDATA_W-1:0]  m_axis_tdata_o;        // [9:0] result_descriptor, [41:10] result_handle
  logic [STATUS_W-1:0] m_axis_tuser_o;        // [1:0] status

  descriptor_table_allocator dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #5 clk_i = ~clk_i;

  // Shadow table state
  logic [HANDLE_W-1:0] shadow_handles [TABLE_ENTRIES];
  int                  shadow_free;
  int                  shadow_top;

  res_t pending_results[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;
  int errors         = 0;
  int quiet_cycles   = 0;

  function automatic bit desc_live(input int idx);
    return idx >= FIRST_USER && idx < TABLE_ENTRIES && shadow_handles[idx] != '0;
  endfunction

  // Applies one word to the shadow table and returns the word it yields
  function automatic res_t predict_table_op(input logic [MODE_W-1:0]   mode,
                                            input logic [DESC_W-1:0]   desc,
                                            input logic [HANDLE_W-1:0] handle);
    res_t r;
    int   slot;
    r.status  = ST_BAD;
    r.rdesc   = '0;
    r.rhandle = '0;
    case (mode)
      MODE_OPEN: begin
        if (shadow_free >= TABLE_ENTRIES) begin
          r.status = ST_FULL;
        end else if (handle == '0) begin
          r.status = ST_FAIL;
        end else begin
          slot = shadow_free;
          shadow_handles[slot] = handle;
          if (slot > shadow_top) shadow_top = slot;
          shadow_free = slot + 1;
          while (shadow_free < TABLE_ENTRIES && shadow_handles[shadow_free] != '0)
            shadow_free++;
          r.status = ST_OK;
          r.rdesc  = DESC_W'(slot);
        end
      end
      MODE_CLOSE: begin
        if (desc_live(int'(desc))) begin
          shadow_handles[desc] = '0;
          if (int'(desc) < shadow_free) shadow_free = int'(desc);
          while (shadow_top >= FIRST_USER && shadow_handles[shadow_top] == '0)
            shadow_top--;
          r.status = ST_OK;
        end
      end
      MODE_LOOKUP: begin
        if (desc_live(int'(desc))) begin
          r.rhandle = shadow_handles[desc];
          r.status  = ST_OK;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [HANDLE_W-1:0] nonzero_handle();
    logic [HANDLE_W-1:0] h;
    h = $urandom;
    return (h == '0) ? 32'd1 : h;
  endfunction

  // A descriptor that currently holds a handle, or a random one if none does
  function automatic logic [DESC_W-1:0] pick_live_desc();
    int idx;
    if (shadow_top < FIRST_USER) return DESC_W'($urandom_range(TABLE_ENTRIES - 1));
    for (int tries = 0; tries < 32; tries++) begin
      idx = $urandom_range(shadow_top, FIRST_USER);
      if (shadow_handles[idx] != '0) return DESC_W'(idx);
    end
    return DESC_W'(shadow_top);
  endfunction

  // Offers one word, waits for the handshake, then predicts its result
  task automatic send_word(input logic [MODE_W-1:0]   mode,
                           input logic [DESC_W-1:0]   desc,
                           input logic [HANDLE_W-1:0] handle);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= TDATA_W'({handle, desc});
    s_axis_tuser_i  <= mode;
    do @(posedge clk_i); while (!s_axis_tready_o);
    pending_results.push_back(predict_table_op(mode, desc, handle));
  endtask

  task automatic wait_results_drained();
    s_axis_tvalid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Output side: check accepted words, then choose tready for the next edge
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_results.size() == 0) begin
        $error("unexpected word: status %0d desc %0d handle %h",
               m_axis_tuser_o, m_axis_tdata_o[DESC_W-1:0],
               m_axis_tdata_o[DESC_W +: HANDLE_W]);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tuser_o != want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_axis_tuser_o);
          errors++;
        end
        if (m_axis_tdata_o[DESC_W-1:0] != want.rdesc) begin
          $error("result_descriptor: expected %0d, got %0d",
                 want.rdesc, m_axis_tdata_o[DESC_W-1:0]);
          errors++;
        end
        if (m_axis_tdata_o[DESC_W +: HANDLE_W] != want.rhandle) begin
          $error("result_handle: expected %h, got %h",
                 want.rhandle, m_axis_tdata_o[DESC_W +: HANDLE_W]);
          errors++;
        end
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Hang detection: no word moving on either side for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic test_directed_cases();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_word(MODE_LOOKUP, 10'd2,    32'h0);          // empty slot
    send_word(MODE_CLOSE,  10'd1023, 32'h0);          // empty top slot
    send_word(MODE_LOOKUP, 10'd0,    32'h0);          // reserved
    send_word(MODE_CLOSE,  10'd1,    32'hFFFFFFFF);   // reserved
    send_word(MODE_OPEN,   10'd0,    32'h0);          // zero handle
    send_word(MODE_OPEN,   10'd1023, 32'hFFFFFFFF);   // -> 2
    send_word(MODE_OPEN,   10'd0,    32'h00000001);   // -> 3
    send_word(MODE_OPEN,   10'd512,  32'hA5A5A5A5);   // -> 4
    send_word(MODE_LOOKUP, 10'd2,    32'h0);
    send_word(MODE_LOOKUP, 10'd3,    32'hFFFFFFFF);
    send_word(MODE_LOOKUP, 10'd4,    32'h0);
    send_word(2'd3,        10'd3,    32'h5A5A5A5A);   // unused mode
    send_word(2'd3,        10'd1023, 32'hFFFFFFFF);   // unused mode, all ones
    send_word(MODE_CLOSE,  10'd3,    32'h0);          // hole below the free pointer
    send_word(MODE_LOOKUP, 10'd3,    32'h0);
    send_word(MODE_OPEN,   10'd0,    32'h5A5A5A5A);   // refills 3, scans on to 5
    send_word(MODE_CLOSE,  10'd4,    32'h0);          // top moves down
    send_word(MODE_CLOSE,  10'd3,    32'h0);
    send_word(MODE_CLOSE,  10'd2,    32'h0);          // table empty again
    send_word(MODE_OPEN,   10'd0,    32'h12345678);   // -> 2
    send_word(MODE_LOOKUP, 10'd1023, 32'h0);
    send_word(MODE_LOOKUP, 10'd1,    32'hFFFFFFFF);
    wait_results_drained();
  endtask

  // Mostly well-formed traffic with a share of zero handles, unused modes and
  // descriptors that are reserved, empty or random
  task automatic test_random_traffic(input int words, input int open_w, input int close_w);
    int pick;
    for (int n = 0; n < words; n++) begin
      pick = $urandom_range(99);
      if (pick < 4) begin
        send_word(MODE_W'($urandom_range(3)), DESC_W'($urandom), $urandom);
      end else if (pick < 6) begin
        send_word(MODE_OPEN, DESC_W'($urandom), '0);
      end else if (pick < 10) begin
        send_word(MODE_W'($urandom_range(2, 1)), DESC_W'($urandom), $urandom);
      end else begin
        pick = $urandom_range(99);
        if (pick < open_w)
          send_word(MODE_OPEN, DESC_W'($urandom), nonzero_handle());
        else if (pick < open_w + close_w)
          send_word(MODE_CLOSE, pick_live_desc(), $urandom);
        else
          send_word(MODE_LOOKUP, pick_live_desc(), $urandom);
      end
    end
  endtask

  // Opens until the table is full while the output is held off at first,
  // then checks the full-table behavior and the forward scan at the end
  task automatic test_fill_until_full();
    send_idle_pct  = 0;
    recv_stall_pct = 61;
    hold_left      = HOLD_CYCLES;
    while (shadow_free < TABLE_ENTRIES)
      send_word(MODE_OPEN, DESC_W'($urandom), nonzero_handle());
    wait_results_drained();
    send_word(MODE_OPEN,   10'd0,    32'hDEADBEEF);   // full
    send_word(MODE_OPEN,   10'd0,    32'h0);          // full wins over zero handle
    send_word(MODE_LOOKUP, 10'd1023, 32'h0);
    send_word(MODE_CLOSE,  10'd500,  32'h0);
    send_word(MODE_OPEN,   10'd0,    32'hCAFEF00D);   // -> 500, scan runs off the end
    send_word(MODE_OPEN,   10'd0,    32'h00000002);   // full again
    send_word(MODE_LOOKUP, 10'd500,  32'h0);
    wait_results_drained();
  endtask

  // Frees slots 900..1023 with the top slot last, so the downward scan of the
  // highest used index has to cross several bitmap rows
  task automatic test_release_upper_block();
    send_idle_pct  = 22;
    recv_stall_pct = 22;
    for (int d = 900; d < TABLE_ENTRIES - 1; d++)
      send_word(MODE_CLOSE, DESC_W'(d), $urandom);
    send_word(MODE_CLOSE,  10'd1023, 32'h0);
    send_word(MODE_LOOKUP, 10'd950,  32'h0);
    send_word(MODE_OPEN,   10'd0,    nonzero_handle());  // -> 900
    wait_results_drained();
  endtask

  initial begin
    for (int i = 0; i < TABLE_ENTRIES; i++) shadow_handles[i] = '0;
    shadow_free = FIRST_USER;
    shadow_top  = FIRST_USER - 1;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed_cases();

    send_idle_pct  = 61;
    recv_stall_pct = 0;
    test_random_traffic(300, 45, 25);
    wait_results_drained();

    test_fill_until_full();
    test_release_upper_block();

    send_idle_pct  = 22;
    recv_stall_pct = 22;
    test_random_traffic(150, 20, 55);
    wait_results_drained();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_traffic(100, 40, 30);
    wait_results_drained();

    // catch any stray words after the last expected one
    repeat (50) @(posedge clk_i);
    if (errors == 0 && pending_results.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

>>> files.f
hw/rtl/dta_pkg.sv
hw/rtl/dta_ram.sv
hw/rtl/dta_ctrl.sv
hw/rtl/descriptor_table_allocator.sv
tb/sv/tb_descriptor_table_allocator.sv
